// ===== design/hrlp_pkg.sv =====
package hrlp_pkg;

    localparam int BYTE_W  = 8;
    localparam int TAG_W   = 3;
    localparam int TOTAL_W = 16;

    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_D0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_D9    = 8'h39;

    localparam logic [TAG_W-1:0] TAG_NONE     = 3'd0;
    localparam logic [TAG_W-1:0] TAG_METHOD   = 3'd1;
    localparam logic [TAG_W-1:0] TAG_PATH     = 3'd2;
    localparam logic [TAG_W-1:0] TAG_QUERY    = 3'd3;
    localparam logic [TAG_W-1:0] TAG_FRAGMENT = 3'd4;
    localparam logic [TAG_W-1:0] TAG_VERSION  = 3'd5;

    // One classified input beat as it sits in the queue.
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              is_sp;
        logic              is_cr;
        logic              is_lf;
        logic              is_upper;
        logic              is_query;
        logic              is_hash;
        logic              is_pct;
        logic              is_hex;
        logic [3:0]        hex_val;
    } byte_class_t;

endpackage

// ===== design/hrlp_front.sv =====
module hrlp_front
(
    input  logic [hrlp_pkg::BYTE_W-1:0] in_byte,
    output hrlp_pkg::byte_class_t       cls
);

    logic is_digit;
    logic is_uhex;
    logic is_lhex;

    always_comb
    begin
        is_digit = (in_byte >= hrlp_pkg::CH_D0) && (in_byte <= hrlp_pkg::CH_D9);
        is_uhex  = (in_byte >= hrlp_pkg::CH_UP_A) && (in_byte <= hrlp_pkg::CH_UP_F);
        is_lhex  = (in_byte >= hrlp_pkg::CH_LO_A) && (in_byte <= hrlp_pkg::CH_LO_F);

        cls.ch       = in_byte;
        cls.is_sp    = (in_byte == hrlp_pkg::CH_SP);
        cls.is_cr    = (in_byte == hrlp_pkg::CH_CR);
        cls.is_lf    = (in_byte == hrlp_pkg::CH_LF);
        cls.is_upper = (in_byte >= hrlp_pkg::CH_UP_A) && (in_byte <= hrlp_pkg::CH_UP_Z);
        cls.is_query = (in_byte == hrlp_pkg::CH_QUERY);
        cls.is_hash  = (in_byte == hrlp_pkg::CH_HASH);
        cls.is_pct   = (in_byte == hrlp_pkg::CH_PCT);
        cls.is_hex   = is_digit || is_uhex || is_lhex;

        // Letters A-F and a-f differ only in bit 5, so the low nibble plus nine works for both.
        if (is_digit)
        begin
            cls.hex_val = in_byte[3:0];
        end
        else
        begin
            cls.hex_val = 4'(in_byte[3:0] + 4'd9);
        end
    end

endmodule

// ===== design/hrlp_queue.sv =====
module hrlp_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/hrlp_back.sv =====
module hrlp_back
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  hrlp_pkg::byte_class_t        cls,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         counted,
    output logic [hrlp_pkg::TAG_W-1:0]   field_tag,
    output logic [hrlp_pkg::BYTE_W-1:0]  field_byte,
    output logic                         byte_valid,
    output logic                         line_complete,
    output logic                         bad_request,
    output logic [hrlp_pkg::TOTAL_W-1:0] counted_total
);

    typedef enum logic [3:0] {
        PH_WAIT_METHOD,
        PH_METHOD,
        PH_WAIT_PATH,
        PH_PATH,
        PH_QUERY,
        PH_FRAGMENT,
        PH_WAIT_VERSION,
        PH_VERSION,
        PH_DONE,
        PH_ERROR
    } phase_t;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_ONE  = 2'd2;

    localparam int CMP_W = (COUNT_BITS > hrlp_pkg::TOTAL_W) ? COUNT_BITS : hrlp_pkg::TOTAL_W;

    phase_t                         phase_reg;
    phase_t                         phase_next;
    phase_t                         phase_cur;
    logic [1:0]                     esc_reg;
    logic [1:0]                     esc_next;
    logic [3:0]                     nib_reg;
    logic [3:0]                     nib_next;
    logic                           bad_reg;
    logic                           bad_next;
    logic [COUNT_BITS-1:0]          cnt_reg;
    logic [COUNT_BITS-1:0]          cnt_next;
    logic [CMP_W-1:0]               cnt_wide;

    logic [1:0]                     dec_esc;
    logic [3:0]                     dec_nib;
    logic                           dec_bad;
    logic                           dec_emit;
    logic [hrlp_pkg::BYTE_W-1:0]    dec_byte;

    logic                           is_eol;
    logic                           is_counted;
    logic [hrlp_pkg::TAG_W-1:0]     tag_c;
    logic [hrlp_pkg::BYTE_W-1:0]    byte_c;
    logic                           valid_c;

    logic                           out_valid_reg;
    logic                           counted_reg;
    logic [hrlp_pkg::TAG_W-1:0]     tag_reg;
    logic [hrlp_pkg::BYTE_W-1:0]    byte_reg;
    logic                           byte_valid_reg;
    logic                           complete_reg;
    logic                           error_reg;
    logic [hrlp_pkg::TOTAL_W-1:0]   total_reg;
    logic [hrlp_pkg::TOTAL_W-1:0]   total_next;

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    assign out_valid     = out_valid_reg;
    assign counted       = counted_reg;
    assign field_tag     = tag_reg;
    assign field_byte    = byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign line_complete = complete_reg;
    assign bad_request   = error_reg;
    assign counted_total = total_reg;

    // Percent decoder for one path beat.
    always_comb
    begin
        dec_esc  = esc_reg;
        dec_nib  = nib_reg;
        dec_bad  = bad_reg;
        dec_emit = 1'b0;
        dec_byte = cls.ch;
        if (esc_reg == ESC_IDLE)
        begin
            if (cls.is_pct)
            begin
                dec_esc = ESC_PCT;
            end
            else
            begin
                dec_emit = 1'b1;
            end
        end
        else if (!cls.is_hex)
        begin
            dec_bad = 1'b1;
            dec_esc = ESC_IDLE;
        end
        else if (esc_reg == ESC_PCT)
        begin
            dec_nib = cls.hex_val;
            dec_esc = ESC_ONE;
        end
        else
        begin
            dec_byte = {nib_reg, cls.hex_val};
            dec_esc  = ESC_IDLE;
            dec_nib  = 4'd0;
            dec_emit = 1'b1;
        end
    end

    always_comb
    begin
        is_eol     = cls.is_cr || cls.is_lf;
        is_counted = !cls.is_sp && !is_eol;

        // An end of line outside the version field, before the line is done, ends the line as bad before anything else.
        if (is_eol && (phase_reg != PH_VERSION) && (phase_reg != PH_DONE))
        begin
            phase_cur = PH_ERROR;
        end
        else
        begin
            phase_cur = phase_reg;
        end

        phase_next = phase_cur;
        esc_next   = esc_reg;
        nib_next   = nib_reg;
        bad_next   = bad_reg;
        tag_c      = hrlp_pkg::TAG_NONE;
        byte_c     = cls.ch;
        valid_c    = 1'b0;

        unique case (phase_cur)
            PH_WAIT_METHOD:
            begin
                if (cls.is_upper)
                begin
                    phase_next = PH_METHOD;
                    tag_c      = hrlp_pkg::TAG_METHOD;
                    valid_c    = 1'b1;
                end
            end
            PH_METHOD:
            begin
                if (cls.is_sp)
                begin
                    phase_next = PH_WAIT_PATH;
                end
                else
                begin
                    tag_c   = hrlp_pkg::TAG_METHOD;
                    valid_c = 1'b1;
                end
            end
            PH_WAIT_PATH:
            begin
                if (!cls.is_sp)
                begin
                    phase_next = PH_PATH;
                    esc_next   = dec_esc;
                    nib_next   = dec_nib;
                    bad_next   = dec_bad;
                    byte_c     = dec_byte;
                    valid_c    = dec_emit;
                    tag_c      = hrlp_pkg::TAG_PATH;
                end
            end
            PH_PATH:
            begin
                if (cls.is_query || cls.is_hash || cls.is_sp)
                begin
                    if (bad_reg || (esc_reg != ESC_IDLE))
                    begin
                        phase_next = PH_ERROR;
                    end
                    else if (cls.is_query)
                    begin
                        phase_next = PH_QUERY;
                    end
                    else if (cls.is_hash)
                    begin
                        phase_next = PH_FRAGMENT;
                    end
                    else
                    begin
                        phase_next = PH_WAIT_VERSION;
                    end
                end
                else
                begin
                    esc_next = dec_esc;
                    nib_next = dec_nib;
                    bad_next = dec_bad;
                    byte_c   = dec_byte;
                    valid_c  = dec_emit;
                    tag_c    = hrlp_pkg::TAG_PATH;
                end
            end
            PH_QUERY:
            begin
                if (cls.is_hash)
                begin
                    phase_next = PH_FRAGMENT;
                end
                else if (cls.is_sp)
                begin
                    phase_next = PH_WAIT_VERSION;
                end
                else
                begin
                    tag_c   = hrlp_pkg::TAG_QUERY;
                    valid_c = 1'b1;
                end
            end
            PH_FRAGMENT:
            begin
                if (cls.is_sp)
                begin
                    phase_next = PH_WAIT_VERSION;
                end
                else
                begin
                    tag_c   = hrlp_pkg::TAG_FRAGMENT;
                    valid_c = 1'b1;
                end
            end
            PH_WAIT_VERSION:
            begin
                if (!cls.is_sp)
                begin
                    phase_next = PH_VERSION;
                    tag_c      = hrlp_pkg::TAG_VERSION;
                    valid_c    = 1'b1;
                end
            end
            PH_VERSION:
            begin
                if (cls.is_cr)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    tag_c   = hrlp_pkg::TAG_VERSION;
                    valid_c = 1'b1;
                end
            end
            PH_DONE, PH_ERROR:
            begin
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        if (!valid_c)
        begin
            tag_c  = hrlp_pkg::TAG_NONE;
            byte_c = '0;
        end

        if (is_counted && (cnt_reg != '1))
        begin
            cnt_next = COUNT_BITS'(cnt_reg + 1'b1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        cnt_wide = CMP_W'(cnt_next);
        if (cnt_wide > CMP_W'({hrlp_pkg::TOTAL_W{1'b1}}))
        begin
            total_next = '1;
        end
        else
        begin
            total_next = hrlp_pkg::TOTAL_W'(cnt_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_METHOD;
            esc_reg       <= ESC_IDLE;
            nib_reg       <= 4'd0;
            bad_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                esc_reg       <= esc_next;
                nib_reg       <= nib_next;
                bad_reg       <= bad_next;
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            counted_reg    <= is_counted;
            tag_reg        <= tag_c;
            byte_reg       <= byte_c;
            byte_valid_reg <= valid_c;
            complete_reg   <= (phase_next == PH_DONE);
            error_reg      <= (phase_next == PH_ERROR);
            total_reg      <= total_next;
        end
    end

endmodule

// ===== design/http_request_line_parser.sv =====
// HTTP request-line parser.
// The input channel (in_valid, in_stall, in_byte) carries one raw byte of the
// request line per beat. The output channel (out_valid, out_stall and the result
// fields) carries exactly one result beat per input beat, in order: the byte's
// field tag, the field byte (percent-decoded inside the path), whether it was
// counted, the sticky line_complete and bad_request flags and the saturating
// counted_total.
// A front stage classifies each accepted byte and writes it into a two-entry
// queue; a back stage runs the parse state machine on the queue head and loads
// the output register. A result is registered in a queue entry and then in the
// output register, and one byte per cycle is sustained while out_stall stays low;
// the single state update per byte in the back stage sets that rate.
// When the receiver stalls, the output register holds its beat, the queue fills
// and in_stall rises once both queue entries are taken.
// Reset empties the queue and output register and returns the parser to waiting
// for the first method letter with the byte count at zero. A new line needs a
// reset: after the terminating CR or an error the parser keeps its final state.
module http_request_line_parser
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [hrlp_pkg::BYTE_W-1:0]  in_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         counted,
    output logic [hrlp_pkg::TAG_W-1:0]   field_tag,
    output logic [hrlp_pkg::BYTE_W-1:0]  field_byte,
    output logic                         byte_valid,
    output logic                         line_complete,
    output logic                         bad_request,
    output logic [hrlp_pkg::TOTAL_W-1:0] counted_total
);

    localparam int CLS_W = $bits(hrlp_pkg::byte_class_t);

    hrlp_pkg::byte_class_t front_cls;
    hrlp_pkg::byte_class_t head_cls;
    logic [CLS_W-1:0]      head_bits;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  q_pop;

    assign in_stall = q_full;
    assign head_cls = hrlp_pkg::byte_class_t'(head_bits);

    hrlp_front u_front
    (
        .in_byte (in_byte),
        .cls     (front_cls)
    );

    hrlp_queue
    #(
        .WIDTH (CLS_W),
        .DEPTH (2)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_cls),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_bits),
        .not_empty (q_not_empty)
    );

    hrlp_back
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_not_empty),
        .cls           (head_cls),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .counted       (counted),
        .field_tag     (field_tag),
        .field_byte    (field_byte),
        .byte_valid    (byte_valid),
        .line_complete (line_complete),
        .bad_request   (bad_request),
        .counted_total (counted_total)
    );

endmodule

// ===== design/hrlp_checker.sv =====
module hrlp_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         counted,
    input logic [hrlp_pkg::TAG_W-1:0]   field_tag,
    input logic [hrlp_pkg::BYTE_W-1:0]  field_byte,
    input logic                         byte_valid,
    input logic                         line_complete,
    input logic                         bad_request,
    input logic [hrlp_pkg::TOTAL_W-1:0] counted_total
);

    // A stalled result beat stays on the port.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(field_byte) && $stable(counted_total))
        else $error("result beat changed while stalled");

    // A line cannot be both finished and bad.
    a_done_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(line_complete && bad_request))
        else $error("line_complete and bad_request both set");

    // A field tag is given exactly when a field byte is carried, and empty beats carry zero.
    a_tag_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid == (field_tag != hrlp_pkg::TAG_NONE))
                      && (byte_valid || (field_byte == '0)))
        else $error("field tag and byte_valid disagree");

    // A counted byte leaves the running total above zero.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && counted |-> counted_total != '0)
        else $error("counted byte with zero total");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);

// ===== dv/http_request_line_parser_test.sv =====
`timescale 1ns / 100ps

module http_request_line_parser_test;

    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_BEATS  = 140;

    typedef enum logic [3:0] {
        WAIT_METHOD,
        IN_METHOD,
        WAIT_PATH,
        IN_PATH,
        IN_QUERY,
        IN_FRAGMENT,
        WAIT_VERSION,
        IN_VERSION,
        LINE_ENDED,
        LINE_BAD
    } line_phase_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PERCENT,
        ESC_HIGH
    } escape_t;

    typedef struct packed {
        logic                         counted;
        logic [hrlp_pkg::TAG_W-1:0]   tag;
        logic [hrlp_pkg::BYTE_W-1:0]  fbyte;
        logic                         bvalid;
        logic                         complete;
        logic                         error;
        logic [hrlp_pkg::TOTAL_W-1:0] total;
    } line_beat_t;

    class tag_scoreboard;
        line_phase_t                  phase;
        escape_t                      esc;
        logic [3:0]                   esc_hi;
        logic                         path_bad;
        logic [hrlp_pkg::TOTAL_W-1:0] byte_count;
        line_beat_t                   beats_due[$];
        int                           fail_count;

        function new();
            phase      = WAIT_METHOD;
            esc        = ESC_NONE;
            esc_hi     = '0;
            path_bad   = 1'b0;
            byte_count = '0;
            fail_count = 0;
        endfunction

        // Returns 16 for a byte that is not a hex digit.
        static function logic [4:0] hex_digit(logic [hrlp_pkg::BYTE_W-1:0] c);
            if (c >= hrlp_pkg::CH_D0 && c <= hrlp_pkg::CH_D9)
                return 5'(c - hrlp_pkg::CH_D0);
            if (c >= hrlp_pkg::CH_UP_A && c <= hrlp_pkg::CH_UP_F)
                return 5'(c - hrlp_pkg::CH_UP_A + 8'd10);
            if (c >= hrlp_pkg::CH_LO_A && c <= hrlp_pkg::CH_LO_F)
                return 5'(c - hrlp_pkg::CH_LO_A + 8'd10);
            return 5'd16;
        endfunction

        function bit decode_path_byte(input logic [hrlp_pkg::BYTE_W-1:0] c,
                                      output logic [hrlp_pkg::BYTE_W-1:0] dec);
            logic [4:0] h;
            dec = c;
            if (esc == ESC_NONE)
            begin
                if (c == hrlp_pkg::CH_PCT)
                begin
                    esc = ESC_PERCENT;
                    return 1'b0;
                end
                return 1'b1;
            end
            h = hex_digit(c);
            if (h[4])
            begin
                // The offending byte is dropped and decoding starts over.
                path_bad = 1'b1;
                esc      = ESC_NONE;
                return 1'b0;
            end
            if (esc == ESC_PERCENT)
            begin
                esc_hi = h[3:0];
                esc    = ESC_HIGH;
                return 1'b0;
            end
            dec    = {esc_hi, h[3:0]};
            esc    = ESC_NONE;
            esc_hi = '0;
            return 1'b1;
        endfunction

        function void note_request_byte(logic [hrlp_pkg::BYTE_W-1:0] c);
            line_beat_t                  due;
            logic [hrlp_pkg::BYTE_W-1:0] dec;
            logic [hrlp_pkg::TAG_W-1:0]  tag;
            logic                        is_sp;
            logic                        is_eol;
            logic                        hit;
            is_sp  = (c == hrlp_pkg::CH_SP);
            is_eol = (c == hrlp_pkg::CH_CR) || (c == hrlp_pkg::CH_LF);
            dec    = c;
            tag    = hrlp_pkg::TAG_NONE;
            hit    = 1'b0;
            if (!is_sp && !is_eol && byte_count != '1)
                byte_count++;
            if (is_eol && phase != IN_VERSION && phase != LINE_ENDED)
                phase = LINE_BAD;
            case (phase)
                WAIT_METHOD:
                    if (c >= hrlp_pkg::CH_UP_A && c <= hrlp_pkg::CH_UP_Z)
                    begin
                        phase = IN_METHOD;
                        tag   = hrlp_pkg::TAG_METHOD;
                        hit   = 1'b1;
                    end
                IN_METHOD:
                    if (is_sp)
                        phase = WAIT_PATH;
                    else
                    begin
                        tag = hrlp_pkg::TAG_METHOD;
                        hit = 1'b1;
                    end
                WAIT_PATH:
                    // The first path byte is never a delimiter.
                    if (!is_sp)
                    begin
                        phase = IN_PATH;
                        tag   = hrlp_pkg::TAG_PATH;
                        hit   = decode_path_byte(c, dec);
                    end
                IN_PATH:
                    if (c == hrlp_pkg::CH_QUERY || c == hrlp_pkg::CH_HASH || is_sp)
                    begin
                        if (path_bad || esc != ESC_NONE)
                            phase = LINE_BAD;
                        else if (c == hrlp_pkg::CH_QUERY)
                            phase = IN_QUERY;
                        else if (c == hrlp_pkg::CH_HASH)
                            phase = IN_FRAGMENT;
                        else
                            phase = WAIT_VERSION;
                    end
                    else
                    begin
                        tag = hrlp_pkg::TAG_PATH;
                        hit = decode_path_byte(c, dec);
                    end
                IN_QUERY:
                    if (c == hrlp_pkg::CH_HASH)
                        phase = IN_FRAGMENT;
                    else if (is_sp)
                        phase = WAIT_VERSION;
                    else
                    begin
                        tag = hrlp_pkg::TAG_QUERY;
                        hit = 1'b1;
                    end
                IN_FRAGMENT:
                    if (is_sp)
                        phase = WAIT_VERSION;
                    else
                    begin
                        tag = hrlp_pkg::TAG_FRAGMENT;
                        hit = 1'b1;
                    end
                WAIT_VERSION:
                    if (!is_sp)
                    begin
                        phase = IN_VERSION;
                        tag   = hrlp_pkg::TAG_VERSION;
                        hit   = 1'b1;
                    end
                IN_VERSION:
                    if (c == hrlp_pkg::CH_CR)
                        phase = LINE_ENDED;
                    else
                    begin
                        tag = hrlp_pkg::TAG_VERSION;
                        hit = 1'b1;
                    end
                default:
                    ;
            endcase
            due.counted  = !is_sp && !is_eol;
            due.tag      = hit ? tag : hrlp_pkg::TAG_NONE;
            due.fbyte    = hit ? dec : '0;
            due.bvalid   = hit;
            due.complete = (phase == LINE_ENDED);
            due.error    = (phase == LINE_BAD);
            due.total    = byte_count;
            beats_due.push_back(due);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
                fail_count++;
            end
        endfunction

        function void check_result(line_beat_t seen);
            line_beat_t due;
            if (beats_due.size() == 0)
            begin
                $display("%0t: result beat with none expected, actual %0h", $time, seen);
                fail_count++;
                return;
            end
            due = beats_due.pop_front();
            compare_field("counted", due.counted, seen.counted);
            compare_field("field_tag", due.tag, seen.tag);
            compare_field("field_byte", due.fbyte, seen.fbyte);
            compare_field("byte_valid", due.bvalid, seen.bvalid);
            compare_field("line_complete", due.complete, seen.complete);
            compare_field("bad_request", due.error, seen.error);
            compare_field("counted_total", due.total, seen.total);
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        function void flag_leftovers();
            if (beats_due.size() != 0)
            begin
                $display("%0t: %0d result beats never arrived, expected %0h actual none",
                         $time, beats_due.size(), beats_due[0]);
                fail_count++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [hrlp_pkg::BYTE_W-1:0]  in_byte   = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         counted;
    logic [hrlp_pkg::TAG_W-1:0]   field_tag;
    logic [hrlp_pkg::BYTE_W-1:0]  field_byte;
    logic                         byte_valid;
    logic                         line_complete;
    logic                         bad_request;
    logic [hrlp_pkg::TOTAL_W-1:0] counted_total;

    line_beat_t                   out_beat;
    tag_scoreboard                sb = new();
    int                           stall_pct = 0;
    int                           quiet_cycles = 0;
    logic [hrlp_pkg::BYTE_W-1:0]  request_q[$];

    assign out_beat = {counted, field_tag, field_byte, byte_valid,
                       line_complete, bad_request, counted_total};

    http_request_line_parser u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .counted       (counted),
        .field_tag     (field_tag),
        .field_byte    (field_byte),
        .byte_valid    (byte_valid),
        .line_complete (line_complete),
        .bad_request   (bad_request),
        .counted_total (counted_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bytes that may appear inside a field without ending it.
    function automatic logic [hrlp_pkg::BYTE_W-1:0] random_byte(
        input logic [hrlp_pkg::TAG_W-1:0] field);
        logic [hrlp_pkg::BYTE_W-1:0] b;
        bit                          ok;
        do
        begin
            b  = 8'($urandom_range(0, 255));
            ok = (b != hrlp_pkg::CH_SP) && (b != hrlp_pkg::CH_CR) && (b != hrlp_pkg::CH_LF);
            if (field == hrlp_pkg::TAG_PATH)
                ok = ok && (b != hrlp_pkg::CH_QUERY) && (b != hrlp_pkg::CH_HASH)
                        && (b != hrlp_pkg::CH_PCT);
            if (field == hrlp_pkg::TAG_QUERY)
                ok = ok && (b != hrlp_pkg::CH_HASH);
            if (field == hrlp_pkg::TAG_VERSION)
                ok = (b != hrlp_pkg::CH_CR);
        end
        while (!ok);
        return b;
    endfunction

    function automatic logic [hrlp_pkg::BYTE_W-1:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return hrlp_pkg::CH_D0 + 8'(v);
        if (v < 16)
            return hrlp_pkg::CH_UP_A + 8'(v - 10);
        return hrlp_pkg::CH_LO_A + 8'(v - 16);
    endfunction

    function automatic logic [hrlp_pkg::BYTE_W-1:0] non_hex_char();
        logic [hrlp_pkg::BYTE_W-1:0] b;
        do
            b = random_byte(hrlp_pkg::TAG_PATH);
        while (tag_scoreboard::hex_digit(b) < 5'd16);
        return b;
    endfunction

    task automatic send_byte(input logic [hrlp_pkg::BYTE_W-1:0] b, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request_byte(in_byte);
            if (out_valid && !out_stall)
                sb.check_result(out_beat);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int sender_idle[4];
        int receiver_stall[4];
        int ending;
        int n;
        int bad_at;
        int route;
        int head_len;
        int version_at;
        int idle_pct;

        sender_idle    = '{0, 59, 0, 26};
        receiver_stall = '{0, 0, 59, 26};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Leading junk, a short method, a doubled space, then the first path byte
        // as a delimiter character and escapes in both hex cases.
        request_q = '{8'h00, 8'hFF, 8'h7F, 8'h61, hrlp_pkg::CH_PCT, hrlp_pkg::CH_SP,
                      hrlp_pkg::CH_UP_A, hrlp_pkg::CH_UP_Z, 8'h80,
                      hrlp_pkg::CH_SP, hrlp_pkg::CH_SP};
        request_q.push_back($urandom_range(0, 1) ? hrlp_pkg::CH_QUERY : hrlp_pkg::CH_HASH);
        request_q.push_back(hrlp_pkg::CH_PCT);
        request_q.push_back(8'h34);
        request_q.push_back(8'h31);
        request_q.push_back(hrlp_pkg::CH_PCT);
        request_q.push_back(hrlp_pkg::CH_LO_F);
        request_q.push_back(hrlp_pkg::CH_UP_F);
        request_q.push_back(hrlp_pkg::CH_PCT);
        request_q.push_back(hrlp_pkg::CH_D0);
        request_q.push_back(hrlp_pkg::CH_D0);
        request_q.push_back(8'h2F);
        head_len = request_q.size();

        // Only one line fits between resets, so the seed picks how it ends:
        // cleanly, with a bad escape, with an unfinished escape, or with a stray
        // CR or LF.
        ending = $urandom_range(0, 5);
        n      = $urandom_range(80, 140);
        bad_at = (ending == 3) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++)
        begin
            if (i == bad_at)
            begin
                request_q.push_back(hrlp_pkg::CH_PCT);
                if ($urandom_range(0, 1))
                    request_q.push_back(hex_char());
                request_q.push_back(non_hex_char());
            end
            else if ($urandom_range(0, 99) < 30)
            begin
                request_q.push_back(hrlp_pkg::CH_PCT);
                request_q.push_back(hex_char());
                request_q.push_back(hex_char());
            end
            else
                request_q.push_back(random_byte(hrlp_pkg::TAG_PATH));
        end
        if (ending == 4)
        begin
            request_q.push_back(hrlp_pkg::CH_PCT);
            if ($urandom_range(0, 1))
                request_q.push_back(hex_char());
        end

        route = $urandom_range(0, 3);
        if (route < 2)
        begin
            request_q.push_back(hrlp_pkg::CH_QUERY);
            repeat ($urandom_range(60, 120))
                request_q.push_back(random_byte(hrlp_pkg::TAG_QUERY));
        end
        if (route == 2 || (route < 2 && $urandom_range(0, 1)))
        begin
            request_q.push_back(hrlp_pkg::CH_HASH);
            repeat ($urandom_range(60, 120))
                request_q.push_back(random_byte(hrlp_pkg::TAG_FRAGMENT));
        end
        repeat ($urandom_range(1, 4))
            request_q.push_back(hrlp_pkg::CH_SP);
        version_at = request_q.size();
        request_q.push_back(random_byte(hrlp_pkg::TAG_METHOD));
        repeat ($urandom_range(80, 140))
        begin
            if ($urandom_range(0, 99) < 15)
                request_q.push_back($urandom_range(0, 1) ? hrlp_pkg::CH_SP : hrlp_pkg::CH_LF);
            else
                request_q.push_back(random_byte(hrlp_pkg::TAG_VERSION));
        end
        request_q.push_back(hrlp_pkg::CH_CR);
        if (ending == 5)
            request_q[$urandom_range(head_len, version_at)] =
                $urandom_range(0, 1) ? hrlp_pkg::CH_CR : hrlp_pkg::CH_LF;
        // Bytes after the line ends must only be counted.
        repeat (150)
            request_q.push_back(8'($urandom_range(0, 255)));

        idle_pct = 0;
        foreach (request_q[i])
        begin
            if (i % PHASE_BEATS == 0)
            begin
                wait_drained();
                idle_pct  = sender_idle[(i / PHASE_BEATS) % 4];
                stall_pct = receiver_stall[(i / PHASE_BEATS) % 4];
            end
            send_byte(request_q[i], idle_pct);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        sb.flag_leftovers();
        if (sb.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
design/hrlp_pkg.sv
design/hrlp_front.sv
design/hrlp_queue.sv
design/hrlp_back.sv
design/http_request_line_parser.sv
design/hrlp_checker.sv
dv/http_request_line_parser_test.sv
